>>> hdl/cfc_pkg.sv
// Shared types and constants for the CO2 sensor frame checker.
// Used by every module in the hdl folder; depends on nothing else.
package cfc_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int POS_W       = 4;
  localparam int PPM_W       = 16;
  localparam int AVG_W       = 20;
  localparam int THRESH_W    = 16;

  localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CMD  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HIGH = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LOW  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] CMD_BYTE   = 8'h86;

  localparam logic [AVG_W-1:0]    AVG_MAX        = {AVG_W{1'b1}};
  localparam int                  AVG_RESET_PPM  = 440;
  localparam logic [THRESH_W-1:0] THRESH_RESET   = THRESH_W'(1000);

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_CMD = 2'd1,
    STAT_BAD_SUM = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [PPM_W-1:0] ppm;
    logic [AVG_W-1:0] average;
    logic             alert;
    frame_status_t    status;
  } result_t;

endpackage

>>> hdl/co2_sensor_frame_checker.sv
// CO2 sensor frame checker, top level. Depends on cfc_pkg, cfc_in_stage,
// cfc_frame_core and cfc_out_stage.
// The final frame byte passes through the input register, and its result beat is offered from the result register.
// Throughput: one received byte per cycle;
// a result beat held by the sink holds the input register too.
// Reset (rst, synchronous): hunting for start, threshold 1000, average 440 ppm.
module co2_sensor_frame_checker #(
  parameter int AVG_FRAC_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         threshold_we,
  input  logic [cfc_pkg::THRESH_W-1:0] threshold_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cfc_pkg::PPM_W-1:0]    ppm,
  output logic [cfc_pkg::AVG_W-1:0]    average_ppm,
  output logic                         alert,
  output logic [1:0]                   frame_status
);
  import cfc_pkg::*;

  // Received bytes land in the input register. The frame core consumes the
  // held beat only when the result register can take whatever the beat may
  // produce, so a pending result never gets overwritten. Bytes that produce
  // no result still wait for that, which keeps the control simple; the
  // result register frees its slot as soon as the sink stops stalling.
  logic       held_valid;
  logic [7:0] held_byte;
  logic       take;
  logic       out_free;
  logic       res_valid;
  result_t    res;
  result_t    held_res;

  assign take = held_valid && out_free;

  cfc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // Frame position, checksum, running average and the alert threshold.
  cfc_frame_core #(
    .AVG_FRAC_BITS (AVG_FRAC_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .threshold_we   (threshold_we),
    .threshold_data (threshold_data),
    .take           (take),
    .byte_in        (held_byte),
    .res_valid      (res_valid),
    .res            (res)
  );

  cfc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held_res)
  );

  assign ppm          = held_res.ppm;
  assign average_ppm  = held_res.average;
  assign alert        = held_res.alert;
  assign frame_status = held_res.status;

`ifndef ASSERT_OFF
  // A new result must never land on a beat the sink has not taken yet.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result loaded over a pending beat");

  // A fresh result beat always comes from a byte consumed the cycle before.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(res_valid && take))
    else $error("result beat without a consumed byte");

  // Failed frames report a zero concentration.
  a_failed_ppm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status != STAT_OK) |-> (ppm == '0))
    else $error("nonzero ppm on a failed frame");

  // The core only consumes bytes that are actually held.
  a_take_held: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> held_valid)
    else $error("result without a held byte");
`endif

endmodule

>>> hdl/cfc_in_stage.sv
// Input register for received bytes.
// Depends on cfc_pkg; drained by the frame core one beat per cycle while the result register is free.
module cfc_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);
  import cfc_pkg::*;

  logic accept;

  // The register can load whenever it is empty or is emptied this cycle.
  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

endmodule

>>> hdl/cfc_frame_core.sv
// Frame tracker, checksum test, running average and alert threshold for the frame checker.
// Depends on cfc_pkg; fed by cfc_in_stage and feeds cfc_out_stage.
module cfc_frame_core #(
  parameter int AVG_FRAC_BITS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           threshold_we,
  input  logic [cfc_pkg::THRESH_W-1:0]   threshold_data,
  input  logic                           take,
  input  logic [7:0]                     byte_in,
  output logic                           res_valid,
  output cfc_pkg::result_t               res
);
  import cfc_pkg::*;

  localparam int SHIFTED_W = PPM_W + AVG_FRAC_BITS;
  localparam int SUM_W     = ((SHIFTED_W > AVG_W) ? SHIFTED_W : AVG_W) + 1;
  localparam logic [AVG_W-1:0] AVG_RESET = AVG_W'(AVG_RESET_PPM << AVG_FRAC_BITS);

  logic [POS_W-1:0]    byte_position, byte_position_next;
  logic [7:0]          command_byte, command_byte_next;
  logic [7:0]          value_high, value_high_next;
  logic [7:0]          value_low, value_low_next;
  logic [7:0]          running_sum, running_sum_next;
  logic [AVG_W-1:0]    average_value, average_value_next;
  logic [THRESH_W-1:0] alert_threshold;

  logic [PPM_W-1:0] frame_ppm;
  logic [SUM_W-1:0] avg_sum;
  logic [SUM_W-1:0] avg_half;
  logic [AVG_W-1:0] avg_new;
  frame_status_t    status;

  assign frame_ppm = {value_high, value_low};
  assign avg_sum   = (SUM_W'(frame_ppm) << AVG_FRAC_BITS) + SUM_W'(average_value);
  assign avg_half  = avg_sum >> 1;
  assign avg_new   = (|avg_half[SUM_W-1:AVG_W]) ? AVG_MAX : avg_half[AVG_W-1:0];

  always_comb begin
    byte_position_next = byte_position;
    command_byte_next  = command_byte;
    value_high_next    = value_high;
    value_low_next     = value_low;
    running_sum_next   = running_sum;
    average_value_next = average_value;
    status             = STAT_OK;
    res_valid          = 1'b0;

    if (take) begin
      if (byte_position == POS_HUNT) begin
        if (byte_in == START_BYTE) begin
          byte_position_next = POS_CMD;
          running_sum_next   = 8'd0;
        end
      end else if (byte_position < POS_LAST) begin
        if (byte_position == POS_CMD) begin
          command_byte_next = byte_in;
        end else if (byte_position == POS_HIGH) begin
          value_high_next = byte_in;
        end else if (byte_position == POS_LOW) begin
          value_low_next = byte_in;
        end
        running_sum_next   = running_sum + byte_in;
        byte_position_next = byte_position + POS_W'(1);
      end else begin
        byte_position_next = POS_HUNT;
        res_valid          = 1'b1;
        if (command_byte != CMD_BYTE) begin
          status = STAT_BAD_CMD;
        end else if (byte_in != 8'(-running_sum)) begin
          status = STAT_BAD_SUM;
        end else begin
          status             = STAT_OK;
          average_value_next = avg_new;
        end
      end
    end

    res.ppm     = (status == STAT_OK) ? frame_ppm : '0;
    res.average = average_value_next;
    res.alert   = (average_value_next >> AVG_FRAC_BITS) > AVG_W'(alert_threshold);
    res.status  = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_HUNT;
      command_byte    <= 8'd0;
      value_high      <= 8'd0;
      value_low       <= 8'd0;
      running_sum     <= 8'd0;
      average_value   <= AVG_RESET;
      alert_threshold <= THRESH_RESET;
    end else begin
      byte_position <= byte_position_next;
      command_byte  <= command_byte_next;
      value_high    <= value_high_next;
      value_low     <= value_low_next;
      running_sum   <= running_sum_next;
      average_value <= average_value_next;
      if (threshold_we) begin
        alert_threshold <= threshold_data;
      end
    end
  end

endmodule

>>> hdl/cfc_out_stage.sv
// Result register for the frame checker output channel.
// Depends on cfc_pkg; loaded by cfc_frame_core.
module cfc_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cfc_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output cfc_pkg::result_t held
);
  import cfc_pkg::*;

  // A slot is free when empty or when its beat leaves at this edge.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule
